// File: design/pct_pkg.sv
// Shared constants for the prefix count trie.
package pct_pkg;

  localparam int unsigned NODES       = 4096;
  localparam int unsigned ALPHABET    = 32;
  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned SLOT_W   = $clog2(NODES * ALPHABET);
  localparam int unsigned FREE_W   = NODE_W + 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

endpackage

// File: design/prefix_count_trie_top.sv
// Prefix count trie: sequencer, cursor state and node pool memories.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | op_i, letter_i, last_i
//  out     | output    | out_valid_o/out_stall_i | prefix_count_o, status_o
//
// Each letter runs through a child read, a parent and count read, then the
// update and writes, following the chain of synchronous memory reads.
// A letter of a missed or full word skips the parent and count read.
// A child entry counts as present only if its node is below the free pointer
// and that node's parent entry names the same slot, so no clearing pass runs.
// Reset (rst_ni low, asynchronous) empties the pool at once.
// A last letter waits in the update cycle while the output register is held.
module prefix_count_trie_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [pct_pkg::LETTER_W-1:0] letter_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pct_pkg::OUT_W-1:0]    prefix_count_o,
  output logic                         status_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_VAL  = 2'd2;

  localparam int unsigned NW = pct_pkg::NODE_W;
  localparam int unsigned SW = pct_pkg::SLOT_W;
  localparam int unsigned FW = pct_pkg::FREE_W;
  localparam int unsigned CW = pct_pkg::COUNT_WIDTH;

  logic [1:0]    state_q, state_d;
  logic          op_q, last_q, skip_q, bad_q;
  logic [SW-1:0] slot_q;
  logic [NW-1:0] cursor_q, cursor_d;
  logic          miss_q, miss_d, full_q, full_d;
  logic [FW-1:0] free_q, free_d;
  logic          out_valid_q, out_valid_d;
  logic [pct_pkg::OUT_W-1:0] out_cnt_q, out_cnt_d;
  logic          out_st_q, out_st_d;

  logic          accept, bad_letter, skip, advance, hit;
  logic [SW-1:0] slot;
  logic [NW-1:0] child, new_node;
  logic [SW-1:0] parent;
  logic [CW-1:0] cnt, new_cnt;
  logic          child_we, parent_we, cnt_we;
  logic [NW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign bad_letter = (32'(letter_i) >= pct_pkg::ALPHABET);
  assign skip       = miss_q || full_q || bad_letter;
  assign slot       = SW'(cursor_q) * SW'(pct_pkg::ALPHABET) + SW'(letter_i);
  assign new_node   = free_q[NW-1:0];

  pct_ram #(.DEPTH(pct_pkg::NODES * pct_pkg::ALPHABET), .WIDTH(NW)) u_child (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (slot_q),
    .wdata_i (new_node),
    .re_i    (accept && !skip),
    .raddr_i (slot),
    .rdata_o (child)
  );

  pct_ram #(.DEPTH(pct_pkg::NODES), .WIDTH(SW)) u_parent (
    .clk_i   (clk_i),
    .we_i    (parent_we),
    .waddr_i (new_node),
    .wdata_i (slot_q),
    .re_i    (state_q == S_CHK),
    .raddr_i (child),
    .rdata_o (parent)
  );

  pct_ram #(.DEPTH(pct_pkg::NODES), .WIDTH(CW)) u_count (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (state_q == S_CHK),
    .raddr_i (child),
    .rdata_o (cnt)
  );

  // child is genuine only if allocated and its back pointer matches
  assign hit = (child != '0) && ({1'b0, child} < free_q) && (parent == slot_q);
  assign advance = !last_q || !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    miss_d      = miss_q;
    full_d      = full_q;
    free_d      = free_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    new_cnt     = '0;
    child_we    = 1'b0;
    parent_we   = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = child;
    cnt_wdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = skip ? S_VAL : S_CHK;
        end
      end
      S_CHK: begin
        state_d = S_VAL;
      end
      S_VAL: begin
        if (advance) begin
          state_d = S_IDLE;
          if (!skip_q) begin
            if (op_q == pct_pkg::OP_INSERT) begin
              if (hit) begin
                new_cnt   = (cnt == {CW{1'b1}}) ? cnt : cnt + CW'(1);
                cnt_we    = 1'b1;
                cnt_waddr = child;
                cnt_wdata = new_cnt;
                cursor_d  = child;
              end else if (free_q >= FW'(pct_pkg::NODES)) begin
                full_d = 1'b1;
              end else begin
                new_cnt   = CW'(1);
                child_we  = 1'b1;
                parent_we = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = new_node;
                cnt_wdata = new_cnt;
                cursor_d  = new_node;
                free_d    = free_q + FW'(1);
              end
            end else begin
              if (hit) begin
                new_cnt  = cnt;
                cursor_d = child;
              end else begin
                miss_d = 1'b1;
              end
            end
          end else if (bad_q) begin
            miss_d = 1'b1;
          end

          if (last_q) begin
            out_valid_d = 1'b1;
            if (miss_d || full_d) begin
              out_cnt_d = '0;
            end else if (33'(new_cnt) > 33'(16'hFFFF)) begin
              out_cnt_d = '1;
            end else begin
              out_cnt_d = pct_pkg::OUT_W'(new_cnt);
            end
            out_st_d = full_d ? pct_pkg::ST_FULL : pct_pkg::ST_OK;
            cursor_d = '0;
            miss_d   = 1'b0;
            full_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      miss_q      <= 1'b0;
      full_q      <= 1'b0;
      free_q      <= FW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      miss_q      <= miss_d;
      full_q      <= full_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      last_q <= last_i;
      skip_q <= skip;
      bad_q  <= bad_letter && !miss_q && !full_q;
      slot_q <= slot;
    end
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o    = out_valid_q;
  assign prefix_count_o = out_cnt_q;
  assign status_o       = out_st_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FW'(pct_pkg::NODES))
    else $error("free pointer beyond pool");

  a_free_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != $past(free_q)) |-> (free_q == $past(free_q) + FW'(1)))
    else $error("free pointer moved by more than one");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (prefix_count_o == '0))
    else $error("truncated insert reported a count");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_VAL && $past(last_q)))
    else $error("result raised outside update of a last letter");

endmodule

// File: design/pct_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module pct_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
